@@ design/prd_pkg.sv @@
// Shared types and constants for the partition record decoder.
// Used by the result channel interface and by the top level; depends on nothing.
package prd_pkg;

  // Record layout in bytes.
  localparam logic [3:0] HEADER_BYTES = 4'd3;
  localparam logic [3:0] WORD_BYTES   = 4'd4;
  localparam logic [3:0] TOPIC_LAST   = 4'd15;
  localparam logic [3:0] TOPIC_HALF   = 4'd8;
  localparam logic [3:0] SKIP_BYTES   = 4'd2;

  // Result queue geometry.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = FIFO_AW + 1;

  // Parser phase within the record.
  typedef enum logic [3:0] {
    PH_HEADER = 4'd0,
    PH_PID    = 4'd1,
    PH_TOPIC  = 4'd2,
    PH_RCOUNT = 4'd3,
    PH_REPL   = 4'd4,
    PH_ICOUNT = 4'd5,
    PH_ISR    = 4'd6,
    PH_SKIP   = 4'd7,
    PH_LEADER = 4'd8,
    PH_LEPOCH = 4'd9,
    PH_PEPOCH = 4'd10,
    PH_DONE   = 4'd11
  } phase_t;

  // Result kinds.
  typedef enum logic [3:0] {
    KIND_PID     = 4'd0,
    KIND_TOPIC_H = 4'd1,
    KIND_TOPIC_L = 4'd2,
    KIND_REPLICA = 4'd3,
    KIND_ISR     = 4'd4,
    KIND_LEADER  = 4'd5,
    KIND_LEPOCH  = 4'd6,
    KIND_PEPOCH  = 4'd7,
    KIND_END     = 4'd8
  } kind_t;

  // Record status reported with the end result.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_HDR_SHORT = 2'd1,
    ST_BAD_LIST  = 2'd2,
    ST_PAST_END  = 2'd3
  } status_t;

  // One result item.
  typedef struct packed {
    kind_t       kind;
    logic [63:0] value;
    status_t     status;
    logic        end_of_record;
  } result_t;

endpackage

@@ design/prd_in_if.sv @@
// Input byte channel of the partition record decoder.
// Standalone; carries valid, ready and one record byte with its last flag.
interface prd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

@@ design/prd_out_if.sv @@
// Result channel of the partition record decoder.
// Uses prd_pkg for the kind and status types.
interface prd_out_if;
  logic             valid;
  logic             ready;
  prd_pkg::kind_t   kind;
  logic [63:0]      value;
  prd_pkg::status_t status;
  logic             end_of_record;

  modport source (output valid, output kind, output value, output status,
                  output end_of_record, input ready);
  modport sink   (input valid, input kind, input value, input status,
                  input end_of_record, output ready);
endinterface

@@ design/partition_record_decoder.sv @@
// Top level of the partition record decoder: byte parser and result queue.
// Depends on prd_pkg, prd_in_if and prd_out_if.
//
// Usage: record bytes arrive on in_ch, one per transfer, with last_byte set
// on the final byte of a record. Decoded fields leave on out_ch, one result
// per transfer: partition id, topic id halves, replica and ISR entries,
// leader, leader epoch and partition epoch, then an end result carrying the
// record status. Fields of a failed record are still sent; the receiver
// drops them when the end result reports an error.
// A result enters the result queue when the byte that completes it is
// transferred in, and is offered on out_ch from the queue head. Throughput:
// one byte per cycle while the queue has two free entries. A byte yields
// at most two results (a field plus the end result), which enter a
// four-entry result queue; in_ch.ready is high while the queue has two free
// entries, so only the end of a record adds an extra result to drain.
// Reset (synchronous, rst_n low) empties the queue and puts the parser at
// the start of a record. When the receiver stalls, results stay queued and
// the input stalls once fewer than two queue entries are free.
module partition_record_decoder (
  input  logic      clk,
  input  logic      rst_n,
  prd_in_if.sink    in_ch,
  prd_out_if.source out_ch
);

  // Parser state.
  prd_pkg::phase_t phase_r, phase_nxt;
  logic [3:0]      byte_idx_r, byte_idx_nxt;
  logic [63:0]     acc_r, acc_nxt;
  logic [7:0]      entries_r, entries_nxt;
  prd_pkg::status_t err_r, err_nxt;

  // Result queue.
  prd_pkg::result_t             fifo_r [prd_pkg::FIFO_DEPTH];
  logic [prd_pkg::FIFO_AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [prd_pkg::FIFO_CW-1:0]  count_r, count_nxt;

  logic             in_xfer;
  logic             out_xfer;
  logic             field_vld;
  prd_pkg::kind_t   field_kind;
  logic [63:0]      field_val;
  logic             end_vld;
  prd_pkg::status_t end_status;
  logic [3:0]       idx_inc;
  logic [7:0]       entries_dec;
  prd_pkg::result_t res_field;
  prd_pkg::result_t res_end;
  prd_pkg::result_t slot0;
  logic [1:0]       push_n;

  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign out_xfer = out_ch.valid && out_ch.ready;
  assign idx_inc  = byte_idx_r + 4'd1;
  assign entries_dec = entries_r - 8'd1;

  // Accept a byte while two queue entries are free.
  assign in_ch.ready = (count_r <= prd_pkg::FIFO_CW'(prd_pkg::FIFO_DEPTH - 2));

  // Parse one byte: next state and the field it may complete.
  always_comb begin
    phase_nxt    = phase_r;
    byte_idx_nxt = byte_idx_r;
    acc_nxt      = acc_r;
    entries_nxt  = entries_r;
    err_nxt      = err_r;
    field_vld    = 1'b0;
    field_kind   = prd_pkg::KIND_PID;
    field_val    = acc_r;
    if (err_r == prd_pkg::ST_OK) begin
      case (phase_r)
        prd_pkg::PH_HEADER: begin
          byte_idx_nxt = idx_inc;
          if (idx_inc >= prd_pkg::HEADER_BYTES) begin
            byte_idx_nxt = 4'd0;
            phase_nxt    = prd_pkg::PH_PID;
          end
        end
        prd_pkg::PH_PID, prd_pkg::PH_REPL, prd_pkg::PH_ISR,
        prd_pkg::PH_LEADER, prd_pkg::PH_LEPOCH, prd_pkg::PH_PEPOCH: begin
          acc_nxt      = {acc_r[55:0], in_ch.data_byte};
          byte_idx_nxt = idx_inc;
          field_val    = {32'd0, acc_r[23:0], in_ch.data_byte};
          if (idx_inc >= prd_pkg::WORD_BYTES) begin
            field_vld    = 1'b1;
            acc_nxt      = 64'd0;
            byte_idx_nxt = 4'd0;
            case (phase_r)
              prd_pkg::PH_PID: begin
                field_kind = prd_pkg::KIND_PID;
                phase_nxt  = prd_pkg::PH_TOPIC;
              end
              prd_pkg::PH_REPL: begin
                field_kind  = prd_pkg::KIND_REPLICA;
                entries_nxt = entries_dec;
                if (entries_dec == 8'd0) phase_nxt = prd_pkg::PH_ICOUNT;
              end
              prd_pkg::PH_ISR: begin
                field_kind  = prd_pkg::KIND_ISR;
                entries_nxt = entries_dec;
                if (entries_dec == 8'd0) phase_nxt = prd_pkg::PH_SKIP;
              end
              prd_pkg::PH_LEADER: begin
                field_kind = prd_pkg::KIND_LEADER;
                phase_nxt  = prd_pkg::PH_LEPOCH;
              end
              prd_pkg::PH_LEPOCH: begin
                field_kind = prd_pkg::KIND_LEPOCH;
                phase_nxt  = prd_pkg::PH_PEPOCH;
              end
              default: begin
                field_kind = prd_pkg::KIND_PEPOCH;
                phase_nxt  = prd_pkg::PH_DONE;
              end
            endcase
          end
        end
        prd_pkg::PH_TOPIC: begin
          acc_nxt   = {acc_r[55:0], in_ch.data_byte};
          field_val = {acc_r[55:0], in_ch.data_byte};
          if (byte_idx_r >= prd_pkg::TOPIC_LAST) begin
            field_vld    = 1'b1;
            field_kind   = prd_pkg::KIND_TOPIC_L;
            acc_nxt      = 64'd0;
            byte_idx_nxt = 4'd0;
            phase_nxt    = prd_pkg::PH_RCOUNT;
          end else begin
            byte_idx_nxt = idx_inc;
            if (idx_inc == prd_pkg::TOPIC_HALF) begin
              field_vld  = 1'b1;
              field_kind = prd_pkg::KIND_TOPIC_H;
              acc_nxt    = 64'd0;
            end
          end
        end
        prd_pkg::PH_RCOUNT, prd_pkg::PH_ICOUNT: begin
          if (in_ch.data_byte == 8'd0) begin
            err_nxt = prd_pkg::ST_BAD_LIST;
          end else begin
            entries_nxt  = in_ch.data_byte - 8'd1;
            byte_idx_nxt = 4'd0;
            acc_nxt      = 64'd0;
            if (phase_r == prd_pkg::PH_RCOUNT) begin
              phase_nxt = (entries_nxt != 8'd0) ? prd_pkg::PH_REPL : prd_pkg::PH_ICOUNT;
            end else begin
              phase_nxt = (entries_nxt != 8'd0) ? prd_pkg::PH_ISR : prd_pkg::PH_SKIP;
            end
          end
        end
        prd_pkg::PH_SKIP: begin
          byte_idx_nxt = idx_inc;
          if (idx_inc >= prd_pkg::SKIP_BYTES) begin
            byte_idx_nxt = 4'd0;
            phase_nxt    = prd_pkg::PH_LEADER;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // End-of-record status, judged on the state after this byte.
  always_comb begin
    end_vld = in_ch.last_byte;
    if (err_nxt != prd_pkg::ST_OK) begin
      end_status = err_nxt;
    end else if (phase_nxt >= prd_pkg::PH_DONE) begin
      end_status = prd_pkg::ST_OK;
    end else if (phase_nxt == prd_pkg::PH_HEADER) begin
      end_status = prd_pkg::ST_HDR_SHORT;
    end else if (phase_nxt == prd_pkg::PH_REPL || phase_nxt == prd_pkg::PH_ISR) begin
      end_status = prd_pkg::ST_BAD_LIST;
    end else begin
      end_status = prd_pkg::ST_PAST_END;
    end
  end

  // Results produced by this byte, in order.
  always_comb begin
    res_field.kind          = field_kind;
    res_field.value         = field_val;
    res_field.status        = prd_pkg::ST_OK;
    res_field.end_of_record = 1'b0;
    res_end.kind            = prd_pkg::KIND_END;
    res_end.value           = 64'd0;
    res_end.status          = end_status;
    res_end.end_of_record   = 1'b1;
    slot0  = field_vld ? res_field : res_end;
    push_n = in_xfer ? ({1'b0, field_vld} + {1'b0, end_vld}) : 2'd0;
  end

  assign count_nxt = count_r + prd_pkg::FIFO_CW'(push_n)
                     - prd_pkg::FIFO_CW'(out_xfer);

  // Parser state registers; the last byte returns the parser to record start.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= prd_pkg::PH_HEADER;
      byte_idx_r <= 4'd0;
      acc_r      <= 64'd0;
      entries_r  <= 8'd0;
      err_r      <= prd_pkg::ST_OK;
    end else if (in_xfer) begin
      if (in_ch.last_byte) begin
        phase_r    <= prd_pkg::PH_HEADER;
        byte_idx_r <= 4'd0;
        acc_r      <= 64'd0;
        entries_r  <= 8'd0;
        err_r      <= prd_pkg::ST_OK;
      end else begin
        phase_r    <= phase_nxt;
        byte_idx_r <= byte_idx_nxt;
        acc_r      <= acc_nxt;
        entries_r  <= entries_nxt;
        err_r      <= err_nxt;
      end
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + prd_pkg::FIFO_AW'(push_n);
      rd_ptr_r <= rd_ptr_r + prd_pkg::FIFO_AW'(out_xfer);
      count_r  <= count_nxt;
    end
  end

  // Queue storage: up to two writes per transfer.
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      fifo_r[wr_ptr_r] <= slot0;
    end
    if (push_n == 2'd2) begin
      fifo_r[wr_ptr_r + prd_pkg::FIFO_AW'(1)] <= res_end;
    end
  end

  // Result channel driven from the queue head.
  assign out_ch.valid         = (count_r != '0);
  assign out_ch.kind          = fifo_r[rd_ptr_r].kind;
  assign out_ch.value         = fifo_r[rd_ptr_r].value;
  assign out_ch.status        = fifo_r[rd_ptr_r].status;
  assign out_ch.end_of_record = fifo_r[rd_ptr_r].end_of_record;

  // The queue never holds more than its depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= prd_pkg::FIFO_CW'(prd_pkg::FIFO_DEPTH))
    else $error("result queue overfilled");

  // A last byte always leaves the parser at record start with no error.
  a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_ch.last_byte) |=> (phase_r == prd_pkg::PH_HEADER &&
                                      err_r == prd_pkg::ST_OK &&
                                      byte_idx_r == 4'd0))
    else $error("parser not back at record start after last byte");

  // Once an error is latched the phase freezes until the record ends.
  a_err_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    (err_r != prd_pkg::ST_OK && !(in_xfer && in_ch.last_byte)) |=> $stable(phase_r))
    else $error("phase moved after an error");

  // The header counter stays below the header length.
  a_hdr_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == prd_pkg::PH_HEADER) |-> (byte_idx_r < prd_pkg::HEADER_BYTES))
    else $error("header byte count out of range");

endmodule
